// ----- hw/rtl/prle_pkg.sv -----
// ----------------------------------------------------------------------------
// prle_pkg
// Shared types and constants of the planar PCX run-length decoder.
// ----------------------------------------------------------------------------
package prle_pkg;

  localparam int DEF_MAX_WIDTH       = 1024;
  localparam int DEF_MAX_HEIGHT      = 1024;
  localparam int DEF_MAX_PLANE_BYTES = 128;
  localparam int HEADER_BYTES        = 128;

  localparam logic [6:0] HDR_LAST      = 7'(HEADER_BYTES - 1);
  localparam logic [6:0] HDR_MAGIC     = 7'd0;
  localparam logic [6:0] HDR_XMIN_LO   = 7'd4;
  localparam logic [6:0] HDR_XMIN_HI   = 7'd5;
  localparam logic [6:0] HDR_YMIN_LO   = 7'd6;
  localparam logic [6:0] HDR_YMIN_HI   = 7'd7;
  localparam logic [6:0] HDR_XMAX_LO   = 7'd8;
  localparam logic [6:0] HDR_XMAX_HI   = 7'd9;
  localparam logic [6:0] HDR_YMAX_LO   = 7'd10;
  localparam logic [6:0] HDR_YMAX_HI   = 7'd11;
  localparam logic [6:0] HDR_PAL_FIRST = 7'd16;
  localparam logic [6:0] HDR_PAL_END   = 7'd64;
  localparam logic [6:0] HDR_PLANES    = 7'd65;
  localparam logic [6:0] HDR_BPL_LO    = 7'd66;
  localparam logic [6:0] HDR_BPL_HI    = 7'd67;

  localparam logic [7:0] PCX_MAGIC   = 8'h0A;
  localparam logic [1:0] RUN_MARK    = 2'b11;
  localparam logic [7:0] PLANE_COUNT = 8'd4;

  localparam logic [1:0] KIND_PALETTE = 2'd0;
  localparam logic [1:0] KIND_PIXELS  = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;
  localparam logic [1:0] KIND_END     = 2'd3;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_MAGIC = 2'd1;
  localparam logic [1:0] ERR_GEOM  = 2'd2;
  localparam logic [1:0] ERR_LARGE = 2'd3;

  localparam logic CFG_WIDTH_LIMIT  = 1'b0;
  localparam logic [10:0] RST_WIDTH_LIMIT  = 11'd640;
  localparam logic [10:0] RST_HEIGHT_LIMIT = 11'd350;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_BODY   = 3'b010,
    PH_DRAIN  = 3'b100
  } phase_e;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_HDR_CHK  = 10'b0000000010,
    S_RUN      = 10'b0000000100,
    S_CHECK    = 10'b0000001000,
    S_ROW_RD   = 10'b0000010000,
    S_ROW_CAP  = 10'b0000100000,
    S_ROW_EMIT = 10'b0001000000,
    S_PAL_RD   = 10'b0010000000,
    S_PAL_EMIT = 10'b0100000000,
    S_SINGLE   = 10'b1000000000
  } state_e;

endpackage

// ----- hw/rtl/prle_line_mem.sv -----
// ----------------------------------------------------------------------------
// prle_line_mem
// Row store: one write and one registered read port.
// ----------------------------------------------------------------------------
module prle_line_mem #(
  parameter int DEPTH = 4 * prle_pkg::DEF_MAX_PLANE_BYTES,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hw/rtl/prle_pal_mem.sv -----
// ----------------------------------------------------------------------------
// prle_pal_mem
// Palette store: 16 RGB entries, byte lane writes, registered read.
// ----------------------------------------------------------------------------
module prle_pal_mem (
  input  logic        clk_i,
  input  logic [2:0]  we_i,
  input  logic [3:0]  waddr_i,
  input  logic [7:0]  wdata_i,
  input  logic        re_i,
  input  logic [3:0]  raddr_i,
  output logic [23:0] rdata_o
);

  logic [23:0] mem_q [16];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (we_i[k]) begin
        mem_q[waddr_i][k*8 +: 8] <= wdata_i;
      end
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hw/rtl/pcx_planar_rle_decoder_top.sv -----
// ----------------------------------------------------------------------------
// pcx_planar_rle_decoder_top
// 4-plane PCX decoder: header, palette, RLE rows to packed 4-bit pixels.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel takes one file byte per transfer (end_of_file_i on the last
//  byte). Output channel gives one result per transfer from an output
//  register; a stalled result holds and the decoder waits for the slot.
//  Config writes (index 0 width limit, 1 height limit) are taken any cycle.
//  Steps per byte, set by the sequencer and the one-port row store:
//   header byte: taken in idle; last header byte: header check, then a read
//   and an emit per palette entry; plain body byte: the check; run value
//   byte: the run fill, then the check; a finished row adds, per 16-pixel
//   group, 8 reads of the row store, one capture each, one output load.
//  Reset: header phase, limits 640 x 350, output empty, ready for byte 0.
//  No clearing pass: unfilled row bytes are masked by the fill count.
// ----------------------------------------------------------------------------
module pcx_planar_rle_decoder_top #(
  parameter int MAX_WIDTH       = prle_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = prle_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_PLANE_BYTES = prle_pkg::DEF_MAX_PLANE_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [3:0]  palette_index_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [9:0]  pixel_row_o,
  output logic [5:0]  pixel_group_o,
  output logic [63:0] pixels_o,
  output logic [1:0]  error_code_o,
  output logic        last_of_run_o,
  output logic        frame_done_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int PBW   = $clog2(MAX_PLANE_BYTES + 1);
  localparam int DEPTH = 4 * MAX_PLANE_BYTES;
  localparam int FW    = $clog2(DEPTH + 1);
  localparam int AW    = $clog2(DEPTH);

  prle_pkg::state_e state_q;
  prle_pkg::phase_e phase_q;

  logic [6:0]    hpos_q;
  logic          magic_q;
  logic [15:0]   left_q, top_q, right_q, bottom_q, bpp_q;
  logic [7:0]    planes_q;
  logic [3:0]    pal_entry_q;
  logic [1:0]    pal_lane_q;
  logic [FW-1:0] fill_q;
  logic          run_pend_q;
  logic [5:0]    run_len_q, run_left_q;
  logic [7:0]    run_val_q;
  logic [HW-1:0] row_q, img_h_q;
  logic [WW-1:0] img_w_q;
  logic          eof_q, row_done_q, rd_ok_q;
  logic [5:0]    grp_q;
  logic [2:0]    byte_q;
  logic [63:0]   pix_q, pix_d;
  logic [3:0]    pal_idx_q;
  logic [1:0]    single_kind_q, single_err_q;
  logic [10:0]   wlim_q, hlim_q;
  logic          out_valid_q;

  logic accept, slot_free;
  assign in_stall_o  = (state_q != prle_pkg::S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;

  // row store write
  logic [PBW-1:0] bpp_s;
  logic [FW-1:0]  line_len;
  logic           room, body_plain, lw_en;
  logic [7:0]     lw_data;
  assign bpp_s      = bpp_q[PBW-1:0];
  assign line_len   = FW'({bpp_s, 2'b00});
  assign room       = fill_q < line_len;
  assign body_plain = accept && (phase_q == prle_pkg::PH_BODY) && !run_pend_q
                      && (data_byte_i[7:6] != prle_pkg::RUN_MARK);
  assign lw_en      = room && (body_plain ||
                      ((state_q == prle_pkg::S_RUN) && (run_left_q != 6'd0)));
  assign lw_data    = (state_q == prle_pkg::S_RUN) ? run_val_q : data_byte_i;

  // row store read
  logic [FW:0]   rd_addr_full;
  logic [7:0]    line_rdata;
  logic          row_rd;
  assign row_rd       = (state_q == prle_pkg::S_ROW_RD);
  assign rd_addr_full = ((FW+1)'(byte_q[2:1]) * (FW+1)'(bpp_s))
                        + (FW+1)'({grp_q, byte_q[0]});

  prle_line_mem #(.DEPTH(DEPTH), .AW(AW)) u_line (
    .clk_i   (clk_i),
    .we_i    (lw_en),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (lw_data),
    .re_i    (row_rd),
    .raddr_i (rd_addr_full[AW-1:0]),
    .rdata_o (line_rdata)
  );

  // palette store
  logic [2:0]  pal_we;
  logic [23:0] pal_rdata;
  always_comb begin
    pal_we = 3'b000;
    if (accept && (phase_q == prle_pkg::PH_HEADER) &&
        (hpos_q >= prle_pkg::HDR_PAL_FIRST) && (hpos_q < prle_pkg::HDR_PAL_END)) begin
      pal_we[2'd2 - pal_lane_q] = 1'b1;
    end
  end

  prle_pal_mem u_pal (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pal_entry_q),
    .wdata_i (data_byte_i),
    .re_i    (state_q == prle_pkg::S_PAL_RD),
    .raddr_i (pal_idx_q),
    .rdata_o (pal_rdata)
  );

  // header checks
  logic [17:0] w18, h18;
  logic        w_bad, h_bad, geom_bad, too_large;
  logic [1:0]  hdr_err;
  assign w18      = {2'b00, right_q} - {2'b00, left_q} + 18'd1;
  assign h18      = {2'b00, bottom_q} - {2'b00, top_q} + 18'd1;
  assign w_bad    = w18[17] || (w18 == 18'd0);
  assign h_bad    = h18[17] || (h18 == 18'd0);
  assign geom_bad = w_bad || h_bad || (planes_q != prle_pkg::PLANE_COUNT)
                    || ({bpp_q, 3'b000} < {1'b0, w18});
  assign too_large = (w18 > {7'd0, wlim_q}) || (w18 > 18'(MAX_WIDTH))
                     || (h18 > {7'd0, hlim_q}) || (h18 > 18'(MAX_HEIGHT))
                     || (bpp_q > 16'(MAX_PLANE_BYTES));
  always_comb begin
    if (!magic_q)       hdr_err = prle_pkg::ERR_MAGIC;
    else if (geom_bad)  hdr_err = prle_pkg::ERR_GEOM;
    else if (too_large) hdr_err = prle_pkg::ERR_LARGE;
    else                hdr_err = prle_pkg::ERR_NONE;
  end

  // row sequencing
  logic [6:0]  groups;
  logic        last_grp, row_full, last_row;
  logic [63:0] pix_masked;
  assign groups   = 7'((12'(img_w_q) + 12'd15) >> 4);
  assign last_grp = ({1'b0, grp_q} + 7'd1) == groups;
  assign row_full = !room;
  assign last_row = ((HW+1)'(row_q) + (HW+1)'(1)) == (HW+1)'(img_h_q);

  always_comb begin
    pix_d = pix_q;
    for (int t = 0; t < 8; t++) begin
      pix_d[{byte_q[0], 3'(t), byte_q[2:1]}] =
        pix_q[{byte_q[0], 3'(t), byte_q[2:1]}] | (rd_ok_q & line_rdata[7-t]);
    end
    for (int k = 0; k < 16; k++) begin
      pix_masked[4*k +: 4] = (12'({grp_q, 4'(k)}) < 12'(img_w_q)) ?
                             pix_q[4*k +: 4] : 4'd0;
    end
  end

  // output load
  logic        ld;
  logic [1:0]  ld_kind, ld_err;
  logic        ld_last, ld_done;
  always_comb begin
    ld      = 1'b0;
    ld_kind = prle_pkg::KIND_END;
    ld_err  = prle_pkg::ERR_NONE;
    ld_last = 1'b0;
    ld_done = 1'b0;
    case (state_q)
      prle_pkg::S_ROW_EMIT: begin
        ld      = slot_free;
        ld_kind = prle_pkg::KIND_PIXELS;
        ld_last = last_grp;
        ld_done = last_grp && row_done_q;
      end
      prle_pkg::S_PAL_EMIT: begin
        ld      = slot_free;
        ld_kind = prle_pkg::KIND_PALETTE;
        ld_last = (pal_idx_q == 4'd15) && !eof_q;
      end
      prle_pkg::S_SINGLE: begin
        ld      = slot_free;
        ld_kind = single_kind_q;
        ld_err  = single_err_q;
        ld_last = 1'b1;
        ld_done = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      result_kind_o   <= ld_kind;
      error_code_o    <= ld_err;
      last_of_run_o   <= ld_last;
      frame_done_o    <= ld_done;
      if (state_q == prle_pkg::S_PAL_EMIT) begin
        palette_index_o <= pal_idx_q;
        red_o           <= pal_rdata[23:16];
        green_o         <= pal_rdata[15:8];
        blue_o          <= pal_rdata[7:0];
      end else begin
        palette_index_o <= 4'd0;
        red_o           <= 8'd0;
        green_o         <= 8'd0;
        blue_o          <= 8'd0;
      end
      if (state_q == prle_pkg::S_ROW_EMIT) begin
        pixel_row_o   <= 10'(row_q);
        pixel_group_o <= grp_q;
        pixels_o      <= pix_masked;
      end else begin
        pixel_row_o   <= 10'd0;
        pixel_group_o <= 6'd0;
        pixels_o      <= 64'd0;
      end
    end
  end

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlim_q <= prle_pkg::RST_WIDTH_LIMIT;
      hlim_q <= prle_pkg::RST_HEIGHT_LIMIT;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == prle_pkg::CFG_WIDTH_LIMIT) wlim_q <= cfg_data_i;
      else                                          hlim_q <= cfg_data_i;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= prle_pkg::S_IDLE;
      phase_q       <= prle_pkg::PH_HEADER;
      hpos_q        <= 7'd0;
      magic_q       <= 1'b0;
      left_q        <= 16'd0;
      top_q         <= 16'd0;
      right_q       <= 16'd0;
      bottom_q      <= 16'd0;
      planes_q      <= 8'd0;
      bpp_q         <= 16'd0;
      pal_entry_q   <= 4'd0;
      pal_lane_q    <= 2'd0;
      fill_q        <= '0;
      run_pend_q    <= 1'b0;
      run_len_q     <= 6'd0;
      run_left_q    <= 6'd0;
      run_val_q     <= 8'd0;
      row_q         <= '0;
      img_h_q       <= '0;
      img_w_q       <= '0;
      eof_q         <= 1'b0;
      row_done_q    <= 1'b0;
      rd_ok_q       <= 1'b0;
      grp_q         <= 6'd0;
      byte_q        <= 3'd0;
      pix_q         <= 64'd0;
      pal_idx_q     <= 4'd0;
      single_kind_q <= prle_pkg::KIND_END;
      single_err_q  <= prle_pkg::ERR_NONE;
    end else begin
      if (lw_en) fill_q <= fill_q + FW'(1);
      case (state_q)
        prle_pkg::S_IDLE: begin
          if (accept) begin
            eof_q <= end_of_file_i;
            case (phase_q)
              prle_pkg::PH_HEADER: begin
                case (hpos_q)
                  prle_pkg::HDR_MAGIC: begin
                    magic_q     <= (data_byte_i == prle_pkg::PCX_MAGIC);
                    pal_entry_q <= 4'd0;
                    pal_lane_q  <= 2'd0;
                  end
                  prle_pkg::HDR_XMIN_LO: left_q[7:0]    <= data_byte_i;
                  prle_pkg::HDR_XMIN_HI: left_q[15:8]   <= data_byte_i;
                  prle_pkg::HDR_YMIN_LO: top_q[7:0]     <= data_byte_i;
                  prle_pkg::HDR_YMIN_HI: top_q[15:8]    <= data_byte_i;
                  prle_pkg::HDR_XMAX_LO: right_q[7:0]   <= data_byte_i;
                  prle_pkg::HDR_XMAX_HI: right_q[15:8]  <= data_byte_i;
                  prle_pkg::HDR_YMAX_LO: bottom_q[7:0]  <= data_byte_i;
                  prle_pkg::HDR_YMAX_HI: bottom_q[15:8] <= data_byte_i;
                  prle_pkg::HDR_PLANES:  planes_q       <= data_byte_i;
                  prle_pkg::HDR_BPL_LO:  bpp_q[7:0]     <= data_byte_i;
                  prle_pkg::HDR_BPL_HI:  bpp_q[15:8]    <= data_byte_i;
                  default: ;
                endcase
                if (pal_we != 3'b000) begin
                  if (pal_lane_q == 2'd2) begin
                    pal_lane_q  <= 2'd0;
                    pal_entry_q <= pal_entry_q + 4'd1;
                  end else begin
                    pal_lane_q <= pal_lane_q + 2'd1;
                  end
                end
                if (hpos_q != prle_pkg::HDR_LAST) begin
                  if (end_of_file_i) begin
                    hpos_q        <= 7'd0;
                    single_kind_q <= prle_pkg::KIND_ERROR;
                    single_err_q  <= prle_pkg::ERR_MAGIC;
                    state_q       <= prle_pkg::S_SINGLE;
                  end else begin
                    hpos_q <= hpos_q + 7'd1;
                  end
                end else begin
                  hpos_q  <= 7'd0;
                  state_q <= prle_pkg::S_HDR_CHK;
                end
              end
              prle_pkg::PH_BODY: begin
                if (run_pend_q) begin
                  run_left_q <= run_len_q;
                  run_val_q  <= data_byte_i;
                  run_pend_q <= 1'b0;
                  state_q    <= prle_pkg::S_RUN;
                end else if (data_byte_i[7:6] == prle_pkg::RUN_MARK) begin
                  run_len_q <= data_byte_i[5:0];
                  if (end_of_file_i) begin
                    run_left_q <= data_byte_i[5:0];
                    run_val_q  <= 8'd0;
                    state_q    <= prle_pkg::S_RUN;
                  end else begin
                    run_pend_q <= 1'b1;
                    state_q    <= prle_pkg::S_CHECK;
                  end
                end else begin
                  state_q <= prle_pkg::S_CHECK;
                end
              end
              default: begin
                if (end_of_file_i) phase_q <= prle_pkg::PH_HEADER;
              end
            endcase
          end
        end
        prle_pkg::S_HDR_CHK: begin
          if (hdr_err != prle_pkg::ERR_NONE) begin
            single_kind_q <= prle_pkg::KIND_ERROR;
            single_err_q  <= hdr_err;
            phase_q       <= eof_q ? prle_pkg::PH_HEADER : prle_pkg::PH_DRAIN;
            state_q       <= prle_pkg::S_SINGLE;
          end else begin
            img_w_q    <= w18[WW-1:0];
            img_h_q    <= h18[HW-1:0];
            phase_q    <= prle_pkg::PH_BODY;
            row_q      <= '0;
            run_pend_q <= 1'b0;
            run_len_q  <= 6'd0;
            fill_q     <= '0;
            pal_idx_q  <= 4'd0;
            state_q    <= prle_pkg::S_PAL_RD;
          end
        end
        prle_pkg::S_RUN: begin
          if (run_left_q == 6'd0) state_q <= prle_pkg::S_CHECK;
          else                    run_left_q <= run_left_q - 6'd1;
        end
        prle_pkg::S_CHECK: begin
          grp_q  <= 6'd0;
          byte_q <= 3'd0;
          pix_q  <= 64'd0;
          if (row_full) begin
            row_done_q <= last_row || eof_q;
            if (last_row && !eof_q)      phase_q <= prle_pkg::PH_DRAIN;
            else if (last_row || eof_q)  phase_q <= prle_pkg::PH_HEADER;
            state_q <= prle_pkg::S_ROW_RD;
          end else if (eof_q) begin
            phase_q <= prle_pkg::PH_HEADER;
            if (fill_q != '0) begin
              row_done_q <= 1'b1;
              state_q    <= prle_pkg::S_ROW_RD;
            end else begin
              single_kind_q <= prle_pkg::KIND_END;
              single_err_q  <= prle_pkg::ERR_NONE;
              state_q       <= prle_pkg::S_SINGLE;
            end
          end else begin
            state_q <= prle_pkg::S_IDLE;
          end
        end
        prle_pkg::S_ROW_RD: begin
          rd_ok_q <= rd_addr_full < (FW+1)'(fill_q);
          state_q <= prle_pkg::S_ROW_CAP;
        end
        prle_pkg::S_ROW_CAP: begin
          pix_q  <= pix_d;
          byte_q <= byte_q + 3'd1;
          state_q <= (byte_q == 3'd7) ? prle_pkg::S_ROW_EMIT : prle_pkg::S_ROW_RD;
        end
        prle_pkg::S_ROW_EMIT: begin
          if (slot_free) begin
            if (last_grp) begin
              row_q   <= row_q + HW'(1);
              fill_q  <= '0;
              state_q <= prle_pkg::S_IDLE;
            end else begin
              grp_q   <= grp_q + 6'd1;
              byte_q  <= 3'd0;
              pix_q   <= 64'd0;
              state_q <= prle_pkg::S_ROW_RD;
            end
          end
        end
        prle_pkg::S_PAL_RD: begin
          state_q <= prle_pkg::S_PAL_EMIT;
        end
        prle_pkg::S_PAL_EMIT: begin
          if (slot_free) begin
            if (pal_idx_q == 4'd15) begin
              if (eof_q) begin
                single_kind_q <= prle_pkg::KIND_END;
                single_err_q  <= prle_pkg::ERR_NONE;
                phase_q       <= prle_pkg::PH_HEADER;
                state_q       <= prle_pkg::S_SINGLE;
              end else begin
                state_q <= prle_pkg::S_IDLE;
              end
            end else begin
              pal_idx_q <= pal_idx_q + 4'd1;
              state_q   <= prle_pkg::S_PAL_RD;
            end
          end
        end
        prle_pkg::S_SINGLE: begin
          if (slot_free) state_q <= prle_pkg::S_IDLE;
        end
        default: state_q <= prle_pkg::S_IDLE;
      endcase
    end
  end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Streams generated 4-plane PCX files into the decoder byte by byte and
// checks every result against a cycle-free predictor of the decoder. A table
// of directed files covers header errors, limits and truncation; random files
// follow under changing limits and sender/receiver idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import prle_pkg::*;

  localparam logic CFG_HEIGHT_LIMIT = 1'b1;
  localparam int ROW_STORE = 4 * DEF_MAX_PLANE_BYTES;

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  pidx;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [9:0]  row;
    logic [5:0]  grp;
    logic [63:0] pix;
    logic [1:0]  err;
    logic        last;
    logic        done;
  } dec_result_t;

  typedef struct {
    logic [7:0]  magic;
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic [7:0]  planes;
    logic [15:0] bpl;
    int          hdr_len;   // < 128: eof inside the header
    int          body_len;  // -1 whole body, else cut after this many bytes
    bit          tail_run;  // run count as the final byte
    int          junk;      // trailing bytes after the frame
    logic [1:0]  exp_err;   // ERR_NONE: predictor only
  } pcx_file_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        end_of_file_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [3:0]  palette_index_o;
  logic [7:0]  red_o, green_o, blue_o;
  logic [9:0]  pixel_row_o;
  logic [5:0]  pixel_group_o;
  logic [63:0] pixels_o;
  logic [1:0]  error_code_o;
  logic        last_of_run_o, frame_done_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [10:0] cfg_data_i = '0;

  pcx_planar_rle_decoder_top dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------- decoder predictor ----------------
  logic [10:0] lim_w, lim_h;
  phase_e      dec_phase;
  int          hdr_pos;
  bit          magic_ok;
  logic [15:0] x0, y0, x1, y1, bpl_r;
  logic [7:0]  planes_r;
  logic [23:0] pal [16];
  logic [7:0]  row_buf [ROW_STORE];
  int          fill, run_len, cur_row;
  bit          run_wait;
  dec_result_t step_q[$];
  dec_result_t expected_q[$];
  int          errors = 0;

  function automatic int pic_w();
    return int'(x1) - int'(x0) + 1;
  endfunction

  function automatic int pic_h();
    return int'(y1) - int'(y0) + 1;
  endfunction

  function automatic void add_result(logic [1:0] kind, logic [3:0] pidx, logic [23:0] rgb,
                                     int row, int grp, logic [63:0] pix, logic [1:0] err,
                                     bit done);
    dec_result_t r;
    r.kind = kind; r.pidx = pidx;
    r.red = rgb[23:16]; r.green = rgb[15:8]; r.blue = rgb[7:0];
    r.row = row[9:0]; r.grp = grp[5:0]; r.pix = pix; r.err = err;
    r.last = 1'b0; r.done = done;
    step_q.push_back(r);
  endfunction

  function automatic void clear_row();
    foreach (row_buf[i]) row_buf[i] = '0;
    fill = 0;
  endfunction

  function automatic void store_byte(logic [7:0] v);
    if (fill < 4 * int'(bpl_r) && fill < ROW_STORE) begin
      row_buf[fill] = v;
      fill++;
    end
  endfunction

  function automatic void emit_row(bit done);
    int w, groups, x, idx;
    logic [63:0] pix;
    logic [3:0] nib;
    w = pic_w();
    groups = (w + 15) / 16;
    for (int g = 0; g < groups; g++) begin
      pix = '0;
      for (int k = 0; k < 16; k++) begin
        x = g * 16 + k;
        if (x < w) begin
          for (int p = 0; p < 4; p++) begin
            idx = (p * int'(bpl_r) + x / 8) % ROW_STORE;
            nib[p] = row_buf[idx][7 - x % 8];
          end
          pix[4*k +: 4] = nib;
        end
      end
      add_result(KIND_PIXELS, 0, 0, cur_row, g, pix, ERR_NONE, (g + 1 == groups) && done);
    end
  endfunction

  function automatic void hdr_step(logic [7:0] b, bit eof);
    int w, h;
    logic [1:0] err;
    int e, sh;
    case (hdr_pos)
      0: magic_ok = (b == PCX_MAGIC);
      4: x0[7:0] = b;
      5: x0[15:8] = b;
      6: y0[7:0] = b;
      7: y0[15:8] = b;
      8: x1[7:0] = b;
      9: x1[15:8] = b;
      10: y1[7:0] = b;
      11: y1[15:8] = b;
      65: planes_r = b;
      66: bpl_r[7:0] = b;
      67: bpl_r[15:8] = b;
      default: if (hdr_pos >= 16 && hdr_pos < 64) begin
        e = (hdr_pos - 16) / 3;
        sh = 16 - 8 * ((hdr_pos - 16) % 3);
        pal[e][sh +: 8] = b;
      end
    endcase
    if (hdr_pos + 1 < HEADER_BYTES) begin
      hdr_pos++;
      if (eof) begin
        add_result(KIND_ERROR, 0, 0, 0, 0, 0, ERR_MAGIC, 1);
        hdr_pos = 0;
      end
      return;
    end
    hdr_pos = 0;
    w = pic_w();
    h = pic_h();
    err = ERR_NONE;
    if (!magic_ok) err = ERR_MAGIC;
    else if (w <= 0 || h <= 0 || planes_r != PLANE_COUNT || int'(bpl_r) * 8 < w)
      err = ERR_GEOM;
    else if (w > int'(lim_w) || w > DEF_MAX_WIDTH || h > int'(lim_h) || h > DEF_MAX_HEIGHT ||
             bpl_r > DEF_MAX_PLANE_BYTES)
      err = ERR_LARGE;
    if (err != ERR_NONE) begin
      add_result(KIND_ERROR, 0, 0, 0, 0, 0, err, 1);
      dec_phase = eof ? PH_HEADER : PH_DRAIN;
      return;
    end
    for (int i = 0; i < 16; i++) add_result(KIND_PALETTE, 4'(i), pal[i], 0, 0, 0, ERR_NONE, 0);
    dec_phase = PH_BODY;
    cur_row = 0;
    run_wait = 0;
    run_len = 0;
    clear_row();
    if (eof) begin
      add_result(KIND_END, 0, 0, 0, 0, 0, ERR_NONE, 1);
      dec_phase = PH_HEADER;
    end
  endfunction

  function automatic void body_step(logic [7:0] b, bit eof);
    bit final_row;
    if (run_wait) begin
      for (int i = 0; i < run_len; i++) store_byte(b);
      run_wait = 0;
    end else if (b[7:6] == RUN_MARK) begin
      run_len = b[5:0];
      run_wait = 1;
      if (eof) begin
        for (int i = 0; i < run_len; i++) store_byte(8'h00);
        run_wait = 0;
      end
    end else begin
      store_byte(b);
    end
    if (fill >= 4 * int'(bpl_r)) begin
      final_row = (cur_row + 1 == pic_h());
      emit_row(final_row || eof);
      cur_row++;
      clear_row();
      if (final_row) dec_phase = eof ? PH_HEADER : PH_DRAIN;
      else if (eof) dec_phase = PH_HEADER;
    end else if (eof) begin
      if (fill > 0) emit_row(1);
      else add_result(KIND_END, 0, 0, 0, 0, 0, ERR_NONE, 1);
      dec_phase = PH_HEADER;
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b, bit eof);
    step_q.delete();
    case (dec_phase)
      PH_HEADER: hdr_step(b, eof);
      PH_BODY:   body_step(b, eof);
      default:   if (eof) dec_phase = PH_HEADER;
    endcase
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endfunction

  // ---------------- result checker ----------------
  always @(posedge clk_i) begin
    dec_result_t e;
    if (out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result kind %0d", result_kind_o);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (result_kind_o !== e.kind) begin
          $error("result_kind exp %0d got %0d", e.kind, result_kind_o); errors++;
        end
        if (palette_index_o !== e.pidx) begin
          $error("palette_index exp %0d got %0d", e.pidx, palette_index_o); errors++;
        end
        if (red_o !== e.red) begin
          $error("red exp %0h got %0h", e.red, red_o); errors++;
        end
        if (green_o !== e.green) begin
          $error("green exp %0h got %0h", e.green, green_o); errors++;
        end
        if (blue_o !== e.blue) begin
          $error("blue exp %0h got %0h", e.blue, blue_o); errors++;
        end
        if (pixel_row_o !== e.row) begin
          $error("pixel_row exp %0d got %0d", e.row, pixel_row_o); errors++;
        end
        if (pixel_group_o !== e.grp) begin
          $error("pixel_group exp %0d got %0d", e.grp, pixel_group_o); errors++;
        end
        if (pixels_o !== e.pix) begin
          $error("pixels exp %016h got %016h", e.pix, pixels_o); errors++;
        end
        if (error_code_o !== e.err) begin
          $error("error_code exp %0d got %0d", e.err, error_code_o); errors++;
        end
        if (last_of_run_o !== e.last) begin
          $error("last_of_run exp %0d got %0d", e.last, last_of_run_o); errors++;
        end
        if (frame_done_o !== e.done) begin
          $error("frame_done exp %0d got %0d", e.done, frame_done_o); errors++;
        end
      end
    end
  end

  // ---------------- idling ----------------
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic void set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
      default: begin send_idle_pct = 26; recv_stall_pct = 26; end
    endcase
  endfunction

  // ---------------- drivers ----------------
  task automatic send_byte(logic [7:0] b, bit eof);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    end_of_file_i <= eof;
    do @(posedge clk_i); while (in_stall_o);
    predict_byte(b, eof);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_limit(logic idx, logic [10:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_WIDTH_LIMIT) lim_w = val;
    else lim_h = val;
  endtask

  // ---------------- file generation ----------------
  logic [7:0] file_q[$];

  task automatic build_file(pcx_file_t f);
    int rows, rb, row_fill, n;
    logic [7:0] hdr [HEADER_BYTES];
    logic [7:0] body[$];
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    hdr[HDR_MAGIC] = f.magic;
    {hdr[HDR_XMIN_HI], hdr[HDR_XMIN_LO]} = f.left;
    {hdr[HDR_YMIN_HI], hdr[HDR_YMIN_LO]} = f.top;
    {hdr[HDR_XMAX_HI], hdr[HDR_XMAX_LO]} = f.right;
    {hdr[HDR_YMAX_HI], hdr[HDR_YMAX_LO]} = f.bottom;
    hdr[HDR_PLANES] = f.planes;
    {hdr[HDR_BPL_HI], hdr[HDR_BPL_LO]} = f.bpl;
    file_q.delete();
    for (int i = 0; i < f.hdr_len && i < HEADER_BYTES; i++) file_q.push_back(hdr[i]);
    if (f.hdr_len < HEADER_BYTES || f.exp_err != ERR_NONE) begin
      if (f.hdr_len >= HEADER_BYTES)
        repeat (f.junk) file_q.push_back(8'($urandom));
      return;
    end
    rows = int'(f.bottom) - int'(f.top) + 1;
    rb = 4 * int'(f.bpl);
    if (rows > 0 && rb > 0 && f.body_len != 0) begin
      for (int r = 0; r < rows; r++) begin
        row_fill = 0;
        while (row_fill < rb) begin
          case ($urandom_range(0, 7))
            0, 1, 2: begin
              n = $urandom_range(1, (rb - row_fill + 3 > 63) ? 63 : rb - row_fill + 3);
              body.push_back(8'hC0 | 8'(n));
              body.push_back(8'($urandom));
              row_fill += n;
            end
            3: begin
              body.push_back(8'hC0);
              body.push_back(8'($urandom));
            end
            default: begin
              body.push_back(8'($urandom_range(0, 8'hBF)));
              row_fill++;
            end
          endcase
        end
      end
      if (f.body_len > 0 && f.body_len < body.size()) body = body[0:f.body_len - 1];
    end
    if (f.tail_run) body.push_back(8'hC0 | 8'($urandom_range(0, 63)));
    foreach (body[i]) file_q.push_back(body[i]);
    repeat (f.junk) file_q.push_back(8'($urandom));
  endtask

  task automatic run_file(pcx_file_t f);
    int first_res;
    build_file(f);
    first_res = expected_q.size();
    foreach (file_q[i]) begin
      send_byte(file_q[i], i == file_q.size() - 1);
      if (f.exp_err != ERR_NONE && expected_q.size() > first_res &&
          i == file_q.size() - 1 - f.junk + (f.hdr_len < HEADER_BYTES ? f.junk : 0) &&
          expected_q[first_res].err != f.exp_err) begin
        $error("error_code exp %0d got %0d (prediction)", f.exp_err,
               expected_q[first_res].err);
        errors++;
      end
    end
  endtask

  function automatic pcx_file_t plain_file(int w, int h, int bpl);
    pcx_file_t f;
    f.magic = PCX_MAGIC;
    f.left = 16'($urandom_range(0, 300));
    f.top = 16'($urandom_range(0, 300));
    f.right = f.left + 16'(w - 1);
    f.bottom = f.top + 16'(h - 1);
    f.planes = PLANE_COUNT;
    f.bpl = 16'(bpl);
    f.hdr_len = HEADER_BYTES;
    f.body_len = -1;
    f.tail_run = 0;
    f.junk = 0;
    f.exp_err = ERR_NONE;
    return f;
  endfunction

  function automatic pcx_file_t random_file();
    pcx_file_t f;
    int w, h, r;
    w = ($urandom_range(0, 19) == 0) ? $urandom_range(1, int'(lim_w))
                                     : $urandom_range(1, (lim_w < 64) ? int'(lim_w) : 64);
    h = (w > 128) ? 1 : $urandom_range(1, (lim_h < 4) ? int'(lim_h) : 4);
    f = plain_file(w, h, $urandom_range((w + 7) / 8, ((w + 7) / 8 + 3 > DEF_MAX_PLANE_BYTES)
                                        ? DEF_MAX_PLANE_BYTES : (w + 7) / 8 + 3));
    r = $urandom_range(0, 99);
    if (r < 8) begin
      f.hdr_len = $urandom_range(1, HEADER_BYTES - 1);
    end else if (r < 16) begin
      case ($urandom_range(0, 3))
        0: f.magic = 8'($urandom);
        1: f.planes = 8'($urandom);
        2: f.right = 16'($urandom);
        default: f.bpl = 16'($urandom_range(0, 200));
      endcase
      f.junk = $urandom_range(0, 3);
      f.body_len = 0;
    end else if (r < 30) begin
      f.body_len = $urandom_range(0, 40);
      f.tail_run = ($urandom_range(0, 2) == 0);
    end else if (r < 40) begin
      f.junk = $urandom_range(1, 4);
    end
    return f;
  endfunction

  // ---------------- directed table ----------------
  pcx_file_t directed [$];

  task automatic fill_directed();
    pcx_file_t f;
    f = plain_file(16, 2, 2);                      directed.push_back(f);
    f = plain_file(16, 1, 2); f.hdr_len = 1;
    f.exp_err = ERR_MAGIC;                         directed.push_back(f);
    f = plain_file(16, 1, 2); f.hdr_len = HEADER_BYTES - 1;
    f.exp_err = ERR_MAGIC;                         directed.push_back(f);
    f = plain_file(16, 1, 2); f.magic = 8'h0B;
    f.exp_err = ERR_MAGIC; f.junk = 2;             directed.push_back(f);
    f = plain_file(16, 1, 2); f.right = f.left - 1;
    f.exp_err = ERR_GEOM;                          directed.push_back(f);
    f = plain_file(16, 1, 2); f.top = 16'd5; f.bottom = f.top - 1;
    f.exp_err = ERR_GEOM; f.junk = 1;              directed.push_back(f);
    f = plain_file(8, 1, 1); f.planes = 8'd3;
    f.exp_err = ERR_GEOM;                          directed.push_back(f);
    f = plain_file(17, 1, 2);
    f.exp_err = ERR_GEOM;                          directed.push_back(f);
    f = plain_file(641, 1, 81);
    f.exp_err = ERR_LARGE;                         directed.push_back(f);
    f = plain_file(8, 351, 1);
    f.exp_err = ERR_LARGE;                         directed.push_back(f);
    f = plain_file(8, 1, 129);
    f.exp_err = ERR_LARGE;                         directed.push_back(f);
    f = plain_file(640, 1, 80);                    directed.push_back(f);
    f = plain_file(1, 1, 1); f.left = 16'hFFFF; f.right = 16'hFFFF;
    f.top = 16'hFFFF; f.bottom = 16'hFFFF;         directed.push_back(f);
    f = plain_file(16, 1, 2); f.body_len = 0;      directed.push_back(f);
    f = plain_file(32, 3, 4); f.body_len = 5;      directed.push_back(f);
    f = plain_file(32, 2, 4); f.body_len = 3;
    f.tail_run = 1;                                directed.push_back(f);
    f = plain_file(24, 2, 3); f.junk = 3;          directed.push_back(f);
    f = plain_file(1, 1, 128);                     directed.push_back(f);
  endtask

  // ---------------- main sequence ----------------
  initial begin
    int items, good, phase_no;
    pcx_file_t f;
    lim_w = RST_WIDTH_LIMIT;
    lim_h = RST_HEIGHT_LIMIT;
    dec_phase = PH_HEADER;
    hdr_pos = 0; magic_ok = 0;
    x0 = '0; y0 = '0; x1 = '0; y1 = '0; bpl_r = '0; planes_r = '0;
    foreach (pal[i]) pal[i] = '0;
    clear_row();
    run_wait = 0; run_len = 0; cur_row = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    fill_directed();
    foreach (directed[i]) begin
      set_idling(i);
      run_file(directed[i]);
    end
    wait_drained();

    write_limit(CFG_WIDTH_LIMIT, 11'd1);
    write_limit(CFG_HEIGHT_LIMIT, 11'd1);
    set_idling(3);
    run_file(plain_file(1, 1, 1));
    f = plain_file(2, 1, 1); f.exp_err = ERR_LARGE;
    run_file(f);
    f = plain_file(1, 2, 1); f.exp_err = ERR_LARGE;
    run_file(f);
    wait_drained();
    write_limit(CFG_WIDTH_LIMIT, 11'd1024);
    write_limit(CFG_HEIGHT_LIMIT, 11'd1024);
    run_file(plain_file(1024, 1, 128));
    f = plain_file(1025, 1, 129); f.exp_err = ERR_LARGE;
    run_file(f);

    items = 0;
    good = 0;
    phase_no = 0;
    while (items < 310 || good < 6) begin
      if (phase_no % 3 == 0) begin
        wait_drained();
        write_limit(CFG_WIDTH_LIMIT, 11'($urandom_range(1, 1024)));
        write_limit(CFG_HEIGHT_LIMIT, 11'($urandom_range(1, 1024)));
      end
      if (phase_no == 4) wait_drained();
      set_idling(phase_no);
      f = random_file();
      run_file(f);
      items += file_q.size();
      if (f.hdr_len == HEADER_BYTES && f.body_len != 0) good++;
      phase_no++;
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (expected_q.size() > 0) begin
      $error("%0d results never arrived", expected_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[pcx_planar_rle_decoder_top] OK");
    end else begin
      $display("[pcx_planar_rle_decoder_top] ERROR");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("[pcx_planar_rle_decoder_top] ERROR");
    $finish;
  end

endmodule

// ----- pcx_planar_rle_decoder_top.f -----
hw/rtl/prle_pkg.sv
hw/rtl/prle_line_mem.sv
hw/rtl/prle_pal_mem.sv
hw/rtl/pcx_planar_rle_decoder_top.sv
verif/testbench.sv
